// File: rtl/rpo_pkg.sv
`timescale 1ns / 1ps

package rpo_pkg;

   // Fixed field widths
   localparam int unsigned VAL_W  = 16;
   localparam int unsigned PROD_W = 32;

   // Operation selector codes
   localparam logic [1:0] FUNC_ADD_POW = 2'd0;
   localparam logic [1:0] FUNC_MUL_POW = 2'd1;
   localparam logic [1:0] FUNC_ADD_ORD = 2'd2;
   localparam logic [1:0] FUNC_MUL_ORD = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_APPL = 2'd1;
   localparam logic [1:0] ST_NO_ORDER = 2'd2;

   // Register indexes
   localparam logic CSR_MODULUS   = 1'b0;
   localparam logic CSR_RING_KIND = 1'b1;

   // Datapath micro-operations
   typedef enum logic [5:0] {
      OP_NONE,
      OP_LOAD,
      OP_PRE_NRED,
      OP_WB_NRED,
      OP_PRE_MUL,
      OP_WB_R,
      OP_POW_E,
      OP_POW_D,
      OP_POW_Q,
      OP_PRE_RB,
      OP_PRE_BB,
      OP_WB_BB,
      OP_GCD_INIT,
      OP_PRE_AB,
      OP_WB_AB,
      OP_PRE_MA,
      OP_WB_QUO_R,
      OP_D_SET2,
      OP_PRE_MD,
      OP_D_INC,
      OP_D_DEC,
      OP_TOT_INIT,
      OP_PRE_XD,
      OP_WB_X,
      OP_PRE_TD,
      OP_WB_T,
      OP_PRE_TX,
      OP_ORD_INIT,
      OP_ASC_SKIP,
      OP_PRE_GD,
      OP_D_LAST,
      OP_RES_R,
      OP_RES_ONE,
      OP_RES_CAND,
      OP_RES_NA,
      OP_RES_NF,
      OP_PUSH
   } op_type;

   // Controller states
   typedef enum logic [4:0] {
      S_IDLE,
      S_NRED,
      S_NRED_W,
      S_MUL,
      S_MUL_W,
      S_RES_R,
      S_POWI,
      S_POW,
      S_POW_RB_W,
      S_POW_BB,
      S_POW_BB_W,
      S_POW_END,
      S_ADD,
      S_GCD,
      S_GCD_W,
      S_GDIV_W,
      S_MO,
      S_PT,
      S_PT_W,
      S_CHK1,
      S_TOT,
      S_TOT_W,
      S_TOT_X,
      S_TOTS_W,
      S_TAIL,
      S_TAIL_W,
      S_ORDI,
      S_ASC,
      S_ASC_W,
      S_DSC,
      S_DSC_W,
      S_FIN
   } state_type;

   // Datapath status toward the controller
   typedef struct packed {
      logic       div_done;
      logic       rem_zero;
      logic       quo_ge2;
      logic       m_small;
      logic [1:0] func;
      logic       kind;
      logic       n_zero;
      logic       n_one;
      logic       e_zero;
      logic       e_lsb;
      logic       b_zero;
      logic       dd_gt_m;
      logic       dd_gt_x;
      logic       dd_gt_g;
      logic       x_gt1;
      logic       d_zero;
      logic       d_ge2;
      logic       r_one;
      logic       out_free;
   } stat_type;

endpackage

// File: rtl/rpo_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module rpo_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rpo_pkg::PROD_W-1:0]  dividend,
   input  logic [rpo_pkg::VAL_W-1:0]   divisor,
   output logic                        done,
   output logic [rpo_pkg::PROD_W-1:0]  quo,
   output logic [rpo_pkg::VAL_W-1:0]   rem
);
   import rpo_pkg::*;

   localparam int unsigned CNT_W = $clog2(PROD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [VAL_W-1:0]  rem_ff, rem_in;
   logic [VAL_W-1:0]  dv_ff, dv_in;
   logic [VAL_W:0]    trial;
   logic              fits;

   // One trial subtraction
   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign fits  = trial >= {1'b0, dv_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dv_in   = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[PROD_W-2:0], fits};
         rem_in = fits ? VAL_W'(trial - {1'b0, dv_ff}) : trial[VAL_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

// File: rtl/rpo_dp.sv
`timescale 1ns / 1ps

// Datapath: operand registers, multipliers, shared divider, result register
module rpo_dp #(
   parameter int unsigned MOD_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rpo_pkg::op_type           op,
   output rpo_pkg::stat_type         stat,
   input  logic [1:0]                req_tuser,   // func
   input  logic [31:0]               req_tdata,   // element, exponent
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [23:0]               rsp_tdata,   // value, status, zero pad
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [15:0]               csr_wdata
);
   import rpo_pkg::*;

   localparam int unsigned KW = (MOD_WIDTH < VAL_W) ? MOD_WIDTH : VAL_W;

   // Configuration
   logic [KW-1:0]    modulus_ff, modulus_in;
   logic             kind_ff, kind_in;

   // Working registers
   logic [1:0]       func_ff, func_in;
   logic [VAL_W-1:0] elem_ff, elem_in, exp_ff, exp_in;
   logic [VAL_W-1:0] m_ff, m_in, n_ff, n_in, e_ff, e_in, r_ff, r_in;
   logic [VAL_W-1:0] base_ff, base_in, a_ff, a_in, b_ff, b_in;
   logic [VAL_W-1:0] x_ff, x_in, t_ff, t_in, g_ff, g_in;
   logic [VAL_W-1:0] d_ff, d_in, last_ff, last_in, cand_ff, cand_in;
   logic [PROD_W-1:0] p_ff, p_in;
   logic [VAL_W-1:0] dv_ff, dv_in;
   logic             go_ff, go_in;
   logic [VAL_W-1:0] resv_ff, resv_in;
   logic [1:0]       ress_ff, ress_in;
   logic             ovld_ff, ovld_in;
   logic [VAL_W-1:0] ov_ff, ov_in;
   logic [1:0]       os_ff, os_in;

   logic              div_done;
   logic [PROD_W-1:0] quo;
   logic [VAL_W-1:0]  rem;
   logic [PROD_W-1:0] dd;
   logic              out_free;

   rpo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff),
      .dividend (p_ff),
      .divisor  (dv_ff),
      .done     (div_done),
      .quo      (quo),
      .rem      (rem)
   );

   assign dd       = d_ff * d_ff;
   assign out_free = !ovld_ff || rsp_tready;

   // Status toward the controller
   always_comb begin
      stat.div_done = div_done;
      stat.rem_zero = rem == '0;
      stat.quo_ge2  = quo >= PROD_W'(2);
      stat.m_small  = m_ff < VAL_W'(2);
      stat.func     = func_ff;
      stat.kind     = kind_ff;
      stat.n_zero   = n_ff == '0;
      stat.n_one    = n_ff == VAL_W'(1);
      stat.e_zero   = e_ff == '0;
      stat.e_lsb    = e_ff[0];
      stat.b_zero   = b_ff == '0;
      stat.dd_gt_m  = dd > PROD_W'(m_ff);
      stat.dd_gt_x  = dd > PROD_W'(x_ff);
      stat.dd_gt_g  = dd > PROD_W'(g_ff);
      stat.x_gt1    = x_ff > VAL_W'(1);
      stat.d_zero   = d_ff == '0;
      stat.d_ge2    = d_ff >= VAL_W'(2);
      stat.r_one    = r_ff == VAL_W'(1);
      stat.out_free = out_free;
   end

   // Configuration writes
   always_comb begin
      modulus_in = modulus_ff;
      kind_in    = kind_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODULUS:   modulus_in = csr_wdata[KW-1:0];
            CSR_RING_KIND: kind_in    = csr_wdata[0];
            default:       kind_in    = kind_ff;
         endcase
      end
   end

   // Micro-operation decode
   always_comb begin
      func_in = func_ff;  elem_in = elem_ff;  exp_in  = exp_ff;
      m_in    = m_ff;     n_in    = n_ff;     e_in    = e_ff;
      r_in    = r_ff;     base_in = base_ff;  a_in    = a_ff;
      b_in    = b_ff;     x_in    = x_ff;     t_in    = t_ff;
      g_in    = g_ff;     d_in    = d_ff;     last_in = last_ff;
      cand_in = cand_ff;  p_in    = p_ff;     dv_in   = dv_ff;
      go_in   = 1'b0;     resv_in = resv_ff;  ress_in = ress_ff;
      ovld_in = ovld_ff && !rsp_tready;
      ov_in   = ov_ff;    os_in   = os_ff;
      unique case (op)
         OP_NONE: ;
         OP_LOAD: begin
            func_in = req_tuser;
            elem_in = req_tdata[15:0];
            exp_in  = req_tdata[31:16];
            m_in    = VAL_W'(modulus_ff);
         end
         OP_PRE_NRED: begin
            p_in = PROD_W'(elem_ff); dv_in = m_ff; go_in = 1'b1;
         end
         OP_WB_NRED: n_in = rem;
         OP_PRE_MUL: begin
            p_in = n_ff * exp_ff; dv_in = m_ff; go_in = 1'b1;
         end
         OP_WB_R: r_in = rem;
         OP_POW_E: begin
            r_in = VAL_W'(1); base_in = n_ff; e_in = exp_ff;
         end
         OP_POW_D: begin
            r_in = VAL_W'(1); base_in = n_ff; e_in = d_ff; cand_in = d_ff;
         end
         OP_POW_Q: begin
            r_in = VAL_W'(1); base_in = n_ff; e_in = quo[VAL_W-1:0];
            cand_in = quo[VAL_W-1:0];
         end
         OP_PRE_RB: begin
            p_in = r_ff * base_ff; dv_in = m_ff; go_in = 1'b1;
         end
         OP_PRE_BB: begin
            p_in = base_ff * base_ff; dv_in = m_ff; go_in = 1'b1;
         end
         OP_WB_BB: begin
            base_in = rem; e_in = e_ff >> 1;
         end
         OP_GCD_INIT: begin
            a_in = m_ff; b_in = n_ff;
         end
         OP_PRE_AB: begin
            p_in = PROD_W'(a_ff); dv_in = b_ff; go_in = 1'b1;
         end
         OP_WB_AB: begin
            a_in = b_ff; b_in = rem;
         end
         OP_PRE_MA: begin
            p_in = PROD_W'(m_ff); dv_in = a_ff; go_in = 1'b1;
         end
         OP_WB_QUO_R: r_in = quo[VAL_W-1:0];
         OP_D_SET2:   d_in = VAL_W'(2);
         OP_PRE_MD: begin
            p_in = PROD_W'(m_ff); dv_in = d_ff; go_in = 1'b1;
         end
         OP_D_INC: d_in = d_ff + 1'b1;
         OP_D_DEC: d_in = d_ff - 1'b1;
         OP_TOT_INIT: begin
            t_in = m_ff; x_in = m_ff; d_in = VAL_W'(2);
         end
         OP_PRE_XD: begin
            p_in = PROD_W'(x_ff); dv_in = d_ff; go_in = 1'b1;
         end
         OP_WB_X: x_in = quo[VAL_W-1:0];
         OP_PRE_TD: begin
            p_in = PROD_W'(t_ff); dv_in = d_ff; go_in = 1'b1;
         end
         OP_WB_T: begin
            t_in = t_ff - quo[VAL_W-1:0]; d_in = d_ff + 1'b1;
         end
         OP_PRE_TX: begin
            p_in = PROD_W'(t_ff); dv_in = x_ff; go_in = 1'b1;
         end
         OP_ORD_INIT: begin
            g_in = t_ff; d_in = VAL_W'(1); last_in = '0;
         end
         OP_ASC_SKIP: begin
            last_in = d_ff; d_in = d_ff + 1'b1;
         end
         OP_PRE_GD: begin
            p_in = PROD_W'(g_ff); dv_in = d_ff; go_in = 1'b1; last_in = d_ff;
         end
         OP_D_LAST: d_in = last_ff;
         OP_RES_R: begin
            resv_in = r_ff; ress_in = ST_OK;
         end
         OP_RES_ONE: begin
            resv_in = VAL_W'(1); ress_in = ST_OK;
         end
         OP_RES_CAND: begin
            resv_in = cand_ff; ress_in = ST_OK;
         end
         OP_RES_NA: begin
            resv_in = '0; ress_in = ST_NOT_APPL;
         end
         OP_RES_NF: begin
            resv_in = '0; ress_in = ST_NO_ORDER;
         end
         OP_PUSH: begin
            ovld_in = 1'b1; ov_in = resv_ff; os_in = ress_ff;
         end
         default: ;
      endcase
   end

   // Register update
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= KW'(2);
         kind_ff    <= 1'b0;
         go_ff      <= 1'b0;
         ovld_ff    <= 1'b0;
      end else begin
         modulus_ff <= modulus_in;
         kind_ff    <= kind_in;
         go_ff      <= go_in;
         ovld_ff    <= ovld_in;
      end
      func_ff <= func_in;  elem_ff <= elem_in;  exp_ff  <= exp_in;
      m_ff    <= m_in;     n_ff    <= n_in;     e_ff    <= e_in;
      r_ff    <= r_in;     base_ff <= base_in;  a_ff    <= a_in;
      b_ff    <= b_in;     x_ff    <= x_in;     t_ff    <= t_in;
      g_ff    <= g_in;     d_ff    <= d_in;     last_ff <= last_in;
      cand_ff <= cand_in;  p_ff    <= p_in;     dv_ff   <= dv_in;
      resv_ff <= resv_in;  ress_ff <= ress_in;
      ov_ff   <= ov_in;    os_ff   <= os_in;
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = {6'd0, os_ff, ov_ff};

endmodule

// File: rtl/rpo_ctl.sv
`timescale 1ns / 1ps

// Controller: sequences the datapath micro-operations for one item
module rpo_ctl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  rpo_pkg::stat_type  stat,
   output rpo_pkg::op_type    op
);
   import rpo_pkg::*;

   state_type state_ff, state_in;
   logic      desc_ff, desc_in;
   logic      found_ff, found_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_tvalid) state_in = S_NRED;
         S_NRED:     state_in = stat.m_small ? S_FIN : S_NRED_W;
         S_NRED_W: begin
            if (stat.div_done) begin
               unique case (stat.func)
                  FUNC_ADD_POW: state_in = S_MUL;
                  FUNC_MUL_POW: state_in = S_POWI;
                  FUNC_ADD_ORD: state_in = S_ADD;
                  FUNC_MUL_ORD: state_in = S_MO;
                  default:      state_in = S_MO;
               endcase
            end
         end
         S_MUL:      state_in = S_MUL_W;
         S_MUL_W:    if (stat.div_done) state_in = S_RES_R;
         S_RES_R:    state_in = S_FIN;
         S_POWI:     state_in = S_POW;
         S_POW: begin
            priority if (stat.e_zero) state_in = S_POW_END;
            else if (stat.e_lsb)      state_in = S_POW_RB_W;
            else                      state_in = S_POW_BB_W;
         end
         S_POW_RB_W: if (stat.div_done) state_in = S_POW_BB;
         S_POW_BB:   state_in = S_POW_BB_W;
         S_POW_BB_W: if (stat.div_done) state_in = S_POW;
         S_POW_END: begin
            priority if (stat.func == FUNC_MUL_POW) state_in = S_FIN;
            else if (stat.r_one)                    state_in = S_FIN;
            else if (desc_ff)                       state_in = S_DSC;
            else                                    state_in = S_ASC;
         end
         S_ADD:      state_in = stat.n_zero ? S_FIN : S_GCD;
         S_GCD:      state_in = stat.b_zero ? S_GDIV_W : S_GCD_W;
         S_GCD_W:    if (stat.div_done) state_in = S_GCD;
         S_GDIV_W:   if (stat.div_done) state_in = S_RES_R;
         S_MO:       state_in = stat.kind ? S_CHK1 : S_PT;
         S_PT:       state_in = stat.dd_gt_m ? S_CHK1 : S_PT_W;
         S_PT_W:     if (stat.div_done) state_in = stat.rem_zero ? S_FIN : S_PT;
         S_CHK1:     state_in = stat.n_one ? S_FIN : S_TOT;
         S_TOT:      state_in = stat.dd_gt_x ? S_TAIL : S_TOT_W;
         S_TOT_W: begin
            if (stat.div_done) begin
               priority if (stat.rem_zero) state_in = S_TOT_X;
               else if (found_ff)          state_in = S_TOTS_W;
               else                        state_in = S_TOT;
            end
         end
         S_TOT_X:    state_in = S_TOT_W;
         S_TOTS_W:   if (stat.div_done) state_in = S_TOT;
         S_TAIL:     state_in = stat.x_gt1 ? S_TAIL_W : S_ORDI;
         S_TAIL_W:   if (stat.div_done) state_in = S_ORDI;
         S_ORDI:     state_in = S_ASC;
         S_ASC: begin
            priority if (stat.dd_gt_g) state_in = S_DSC;
            else if (stat.d_ge2)       state_in = S_ASC_W;
            else                       state_in = S_ASC;
         end
         S_ASC_W:    if (stat.div_done) state_in = stat.rem_zero ? S_POW : S_ASC;
         S_DSC:      state_in = stat.d_zero ? S_FIN : S_DSC_W;
         S_DSC_W: begin
            if (stat.div_done)
               state_in = (stat.rem_zero && stat.quo_ge2) ? S_POW : S_DSC;
         end
         S_FIN:      if (stat.out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      op         = OP_NONE;
      req_tready = 1'b0;
      desc_in    = desc_ff;
      found_in   = found_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            desc_in    = 1'b0;
            found_in   = 1'b0;
            if (req_tvalid) op = OP_LOAD;
         end
         S_NRED:     op = stat.m_small ? OP_RES_NA : OP_PRE_NRED;
         S_NRED_W:   if (stat.div_done) op = OP_WB_NRED;
         S_MUL:      op = OP_PRE_MUL;
         S_MUL_W:    if (stat.div_done) op = OP_WB_R;
         S_RES_R:    op = OP_RES_R;
         S_POWI:     op = OP_POW_E;
         S_POW: begin
            priority if (stat.e_zero) op = OP_NONE;
            else if (stat.e_lsb)      op = OP_PRE_RB;
            else                      op = OP_PRE_BB;
         end
         S_POW_RB_W: if (stat.div_done) op = OP_WB_R;
         S_POW_BB:   op = OP_PRE_BB;
         S_POW_BB_W: if (stat.div_done) op = OP_WB_BB;
         S_POW_END: begin
            priority if (stat.func == FUNC_MUL_POW) op = OP_RES_R;
            else if (stat.r_one)                    op = OP_RES_CAND;
            else if (desc_ff)                       op = OP_D_DEC;
            else                                    op = OP_D_INC;
         end
         S_ADD:      op = stat.n_zero ? OP_RES_ONE : OP_GCD_INIT;
         S_GCD:      op = stat.b_zero ? OP_PRE_MA : OP_PRE_AB;
         S_GCD_W:    if (stat.div_done) op = OP_WB_AB;
         S_GDIV_W:   if (stat.div_done) op = OP_WB_QUO_R;
         S_MO:       op = stat.kind ? OP_NONE : OP_D_SET2;
         S_PT:       op = stat.dd_gt_m ? OP_NONE : OP_PRE_MD;
         S_PT_W:     if (stat.div_done) op = stat.rem_zero ? OP_RES_NA : OP_D_INC;
         S_CHK1:     op = stat.n_one ? OP_RES_ONE : OP_TOT_INIT;
         S_TOT:      op = stat.dd_gt_x ? OP_NONE : OP_PRE_XD;
         S_TOT_W: begin
            if (stat.div_done) begin
               priority if (stat.rem_zero) begin
                  op       = OP_WB_X;
                  found_in = 1'b1;
               end else if (found_ff) begin
                  op = OP_PRE_TD;
               end else begin
                  op = OP_D_INC;
               end
            end
         end
         S_TOT_X:    op = OP_PRE_XD;
         S_TOTS_W: begin
            if (stat.div_done) begin
               op       = OP_WB_T;
               found_in = 1'b0;
            end
         end
         S_TAIL:     op = stat.x_gt1 ? OP_PRE_TX : OP_NONE;
         S_TAIL_W:   if (stat.div_done) op = OP_WB_T;
         S_ORDI:     op = OP_ORD_INIT;
         S_ASC: begin
            priority if (stat.dd_gt_g) begin
               op      = OP_D_LAST;
               desc_in = 1'b1;
            end else if (stat.d_ge2) begin
               op = OP_PRE_GD;
            end else begin
               op = OP_ASC_SKIP;
            end
         end
         S_ASC_W:    if (stat.div_done) op = stat.rem_zero ? OP_POW_D : OP_D_INC;
         S_DSC:      op = stat.d_zero ? OP_RES_NF : OP_PRE_GD;
         S_DSC_W: begin
            if (stat.div_done)
               op = (stat.rem_zero && stat.quo_ge2) ? OP_POW_Q : OP_D_DEC;
         end
         S_FIN:      if (stat.out_free) op = OP_PUSH;
         default:    op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         desc_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         desc_ff  <= desc_in;
         found_ff <= found_in;
      end
   end

endmodule

// File: rtl/residue_power_and_order.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// req       in         req_tvalid/req_tready   tuser: func; tdata: element, exponent
// rsp       out        rsp_tvalid/rsp_tready   tdata: value, status
// csr       in         csr_we                  csr_index, csr_wdata
//
// One item at a time; every modular reduction goes through one shared
// 32-bit restoring divider. Powers take up to 2 divisions per exponent
// bit; the multiplicative order runs trial division of m and phi(m) plus
// one power per divisor tried. Synchronous active-high reset; modulus
// resets to 2, ring kind to 0. A waiting result does not stop the next
// item from being accepted; the new result waits until the output
// register is free.
module residue_power_and_order #(
   parameter int unsigned MOD_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] func
   input  logic [31:0] req_tdata,   // [15:0] element, [31:16] exponent
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] value, [17:16] status, rest zero
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import rpo_pkg::*;

   op_type   op;
   stat_type stat;

   rpo_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .op         (op)
   );

   rpo_dp #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

// File: tb/sv/residue_power_and_order_tb.sv
`timescale 1ns / 1ps

module residue_power_and_order_tb;
   import rpo_pkg::*;

   localparam int CYCLE_LIMIT = 30_000_000;
   localparam int MAX_SHOWN   = 10;

   typedef struct {
      logic [1:0]  func;
      logic [15:0] element;
      logic [15:0] exponent;
   } residue_op_type;

   typedef struct {
      logic [15:0] value;
      logic [1:0]  status;
   } residue_ans_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   residue_op_type  op_pending_q[$];
   residue_ans_type answer_q[$];
   residue_op_type  op_on_bus;

   // local copy of the configuration
   logic [15:0] cur_modulus;
   logic        cur_kind;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_reqs;
   int hold_seen;
   int hold_left;
   int mismatches;
   int results_seen;
   int cycles;

   residue_power_and_order dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // modular arithmetic for prediction
   function automatic longint unsigned pow_residue(longint unsigned b,
         longint unsigned e, longint unsigned m);
      longint unsigned r;
      r = 1 % m;
      b = b % m;
      while (e != 0) begin
         if (e[0]) r = (r * b) % m;
         b = (b * b) % m;
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic longint unsigned common_divisor(longint unsigned a,
         longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic bit modulus_is_prime(longint unsigned m);
      longint unsigned d;
      if (m < 2) return 1'b0;
      for (d = 2; d * d <= m; d++)
         if (m % d == 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic longint unsigned euler_phi(longint unsigned m);
      longint unsigned r, x, p;
      r = m;
      x = m;
      for (p = 2; p * p <= x; p++) begin
         if (x % p == 0) begin
            while (x % p == 0) x = x / p;
            r = r - r / p;
         end
      end
      if (x > 1) r = r - r / x;
      return r;
   endfunction

   // smallest divisor >= 2 of the group size that sends n to one, 0 if none
   function automatic longint unsigned unit_order(longint unsigned n,
         longint unsigned m, longint unsigned g);
      longint unsigned d, q, last;
      last = 0;
      for (d = 1; d * d <= g; d++) begin
         last = d;
         if (d >= 2 && g % d == 0 && pow_residue(n, d, m) == 1) return d;
      end
      for (d = last; d >= 1; d--) begin
         if (g % d == 0) begin
            q = g / d;
            if (q >= 2 && pow_residue(n, q, m) == 1) return q;
         end
      end
      return 0;
   endfunction

   function automatic residue_ans_type residue_answer(residue_op_type op);
      residue_ans_type a;
      longint unsigned m, n, v;
      m = cur_modulus;
      n = op.element;
      v = 0;
      a.status = ST_OK;
      if (m < 2) begin
         a.status = ST_NOT_APPL;
      end else begin
         n = n % m;
         case (op.func)
            FUNC_ADD_POW: v = (n * op.exponent) % m;
            FUNC_MUL_POW: v = pow_residue(n, op.exponent, m);
            FUNC_ADD_ORD: v = (n == 0) ? 1 : m / common_divisor(n, m);
            default: begin
               if (!cur_kind && !modulus_is_prime(m)) begin
                  a.status = ST_NOT_APPL;
               end else if (n == 1) begin
                  v = 1;
               end else begin
                  v = unit_order(n, m, euler_phi(m));
                  if (v == 0) a.status = ST_NO_ORDER;
               end
            end
         endcase
      end
      if (a.status != ST_OK) v = 0;
      a.value = v[15:0];
      return a;
   endfunction

   // driver: offer pending items, log the expected answer on acceptance
   always @(posedge clock) begin
      residue_op_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) answer_q = {answer_q, residue_answer(op_on_bus)};
         if (!req_tvalid || req_tready) begin
            if (op_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = op_pending_q.pop_front();
               op_on_bus <= nxt;
               req_tvalid <= 1'b1;
               req_tuser <= nxt.func;
               req_tdata <= {nxt.exponent, nxt.element};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_reqs != hold_seen) begin
         hold_seen <= hold_reqs;
         hold_left <= 3000;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver ready
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: compare each result item against the oldest expectation
   always @(posedge clock) begin
      residue_ans_type exp_ans;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (answer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("unexpected result item: tdata=%h", rsp_tdata);
         end else begin
            exp_ans = answer_q.pop_front();
            if (rsp_tdata !== {6'd0, exp_ans.status, exp_ans.value}) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("mismatch: value exp %0d got %0d, status exp %0d got %0d",
                     exp_ans.value, rsp_tdata[15:0], exp_ans.status, rsp_tdata[17:16]);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("residue_power_and_order_tb failed");
         $finish;
      end
   end

   task automatic queue_op(logic [1:0] f, logic [15:0] el, logic [15:0] ex);
      residue_op_type op;
      op.func = f;
      op.element = el;
      op.exponent = ex;
      op_pending_q = {op_pending_q, op};
   endtask

   task automatic drain_all();
      while (op_pending_q.size() > 0 || req_tvalid || answer_q.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MODULUS) cur_modulus = val;
      else cur_kind = val[0];
   endtask

   task automatic set_ring(logic [15:0] m, logic kind);
      drain_all();
      write_reg(CSR_MODULUS, m);
      write_reg(CSR_RING_KIND, kind);
   endtask

   // random items; elements mostly reduced, some out of range
   task automatic queue_random(int count);
      logic [15:0] el, ex;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(7) == 0 || cur_modulus < 2) el = 16'($urandom);
         else el = 16'($urandom_range(cur_modulus - 1));
         ex = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
         queue_op(2'($urandom_range(3)), el, ex);
      end
   endtask

   task automatic random_ring();
      logic [15:0] m;
      if ($urandom_range(5) == 0) m = 16'($urandom_range(65535, 2));
      else m = 16'($urandom_range(300, 2));
      set_ring(m, 1'($urandom_range(1)));
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_MODULUS;
      csr_wdata = '0;
      cur_modulus = 16'd2;
      cur_kind = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_reqs = 0;
      hold_seen = 0;
      hold_left = 0;
      mismatches = 0;
      results_seen = 0;
      cycles = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset ring: operand extremes, unreduced element, zero degree
      queue_op(FUNC_ADD_POW, 16'd1, 16'hFFFF);
      queue_op(FUNC_MUL_POW, 16'hFFFF, 16'd0);
      queue_op(FUNC_ADD_ORD, 16'd0, 16'd0);
      queue_op(FUNC_MUL_ORD, 16'd1, 16'd0);
      // modulus below two
      set_ring(16'd0, 1'b0);
      for (int f = 0; f < 4; f++) queue_op(2'(f), 16'd5, 16'd3);
      set_ring(16'd1, 1'b1);
      queue_op(FUNC_MUL_ORD, 16'd0, 16'd7);
      // composite in Zn vs Zp, order found and not found
      set_ring(16'd12, 1'b0);
      queue_op(FUNC_MUL_ORD, 16'd5, 16'd0);
      queue_op(FUNC_ADD_ORD, 16'd8, 16'd0);
      set_ring(16'd12, 1'b1);
      queue_op(FUNC_MUL_ORD, 16'd5, 16'd0);
      queue_op(FUNC_MUL_ORD, 16'd4, 16'd0);
      queue_op(FUNC_MUL_ORD, 16'd1, 16'd0);
      // largest moduli
      set_ring(16'd65535, 1'b1);
      queue_op(FUNC_MUL_ORD, 16'd2, 16'd0);
      queue_op(FUNC_MUL_POW, 16'd65534, 16'hFFFF);
      queue_op(FUNC_ADD_POW, 16'd65534, 16'hFFFF);
      queue_op(FUNC_ADD_ORD, 16'd65534, 16'd0);
      set_ring(16'd65521, 1'b0);
      queue_op(FUNC_MUL_ORD, 16'd3, 16'd0);
      queue_op(FUNC_MUL_ORD, 16'd65520, 16'd0);

      // random phases under different idling
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 58 : (ph == 3) ? 27 : 0;
         recv_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 27 : 0;
         for (int k = 0; k < 3; k++) begin
            random_ring();
            queue_random(6);
         end
      end

      // receiver holds off while items keep coming
      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_ring(16'd97, 1'b1);
      hold_reqs++;
      queue_random(8);
      drain_all();

      $display("covered %0d result items over moduli 0..65535, both ring kinds,",
         results_seen);
      $display("all four operations, idle/stall phases and a long output hold-off");
      if (mismatches == 0) begin
         $display("residue_power_and_order_tb passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("residue_power_and_order_tb failed");
      end
      $finish;
   end

endmodule
